### hw/rtl/sspc_pkg.sv
`default_nettype none

package sspc_pkg;

   // defaults for the top level parameters
   localparam int MAX_DIGITS_DEF = 4;
   localparam int FRAME_GAP_DEF  = 25;

   localparam int PIXEL_MAX    = 32;
   localparam int DIGIT_PIXELS = 7;
   localparam int PROG_ONE     = 256;

   // air quality color map
   localparam int AQ_MAX        = 99;
   localparam int AQ_RED_KNEE   = 20;
   localparam int AQ_GREEN_KNEE = 40;
   localparam int AQ_BLUE_KNEE  = 15;

   // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT for x below 81920
   localparam int DIV10_RECIP = 52429;
   localparam int DIV10_SHIFT = 19;

   // progress divider: elapsed (16 bits) scaled by 256
   localparam int DIV_WIDTH = 24;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_NUMBER = 2'd1;
   localparam logic [1:0] CMD_COLOR  = 2'd2;
   localparam logic [1:0] CMD_AQ     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_DIGIT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_PADDING_COUNT = 2'd1;
   localparam logic [1:0] CSR_FADE_MS       = 2'd2;

   localparam logic [2:0]  DIGIT_COUNT_RST   = 3'd4;
   localparam logic [2:0]  PADDING_COUNT_RST = 3'd0;
   localparam logic [15:0] FADE_MS_RST       = 16'd1000;

   typedef struct packed {
      logic load;
      logic now_inc;
      logic aq_map;
      logic color_put;
      logic num_put;
      logic digit_div;
      logic digit_put;
      logic frame_start;
      logic blend;
      logic pix_emit;
   } sspc_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       num_same;
      logic       num_pos;
      logic       digit_done;
      logic       frame_due;
      logic       div_busy;
      logic       div_done;
      logic       pix_none;
      logic       pix_last;
      logic       out_free;
   } sspc_status_type;

   // segment pattern per decimal digit, bit 0 is the first pixel of the digit
   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0: seg = 7'b1110111;
         4'd1: seg = 7'b0100100;
         4'd2: seg = 7'b1011101;
         4'd3: seg = 7'b1101101;
         4'd4: seg = 7'b0101110;
         4'd5: seg = 7'b1101011;
         4'd6: seg = 7'b1111011;
         4'd7: seg = 7'b0100101;
         4'd8: seg = 7'b1111111;
         4'd9: seg = 7'b1101111;
         default: seg = 7'b0000000;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/sspc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module sspc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sspc_pkg::DIV_WIDTH-1:0] dividend,
   input  wire logic [15:0]                    divisor,
   output logic      [sspc_pkg::DIV_WIDTH-1:0] quotient,
   output logic                                busy,
   output logic                                done
);

   localparam int W   = sspc_pkg::DIV_WIDTH;
   localparam int CW  = $clog2(W + 1);

   logic [W-1:0]  work_ff, work_in;
   logic [15:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [16:0]   shifted;
   logic [17:0]   trial;
   logic          ge;

   assign shifted = {rem_ff, work_ff[W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};
   assign ge      = ~trial[17];

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[15:0] : shifted[15:0];
         work_in = {work_ff[W-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient = work_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

### hw/rtl/sspc_dp.sv
`default_nettype none

module sspc_dp #(
   parameter int MAX_DIGITS   = sspc_pkg::MAX_DIGITS_DEF,
   parameter int FRAME_GAP_MS = sspc_pkg::FRAME_GAP_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_wdata,
   input  wire logic [1:0]             req_cmd,
   input  wire logic signed [15:0]     req_number,
   input  wire logic [7:0]             req_red_in,
   input  wire logic [7:0]             req_green_in,
   input  wire logic [7:0]             req_blue_in,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [4:0]                  rsp_pixel_index,
   output logic [7:0]                  rsp_red_out,
   output logic [7:0]                  rsp_green_out,
   output logic [7:0]                  rsp_blue_out,
   output logic                        rsp_last,
   input  wire sspc_pkg::sspc_cmd_type cmd,
   output sspc_pkg::sspc_status_type   status
);

   localparam logic [2:0]  EFF_MAX = 3'(MAX_DIGITS);
   localparam logic [31:0] GAP     = 32'(FRAME_GAP_MS);

   // configuration
   logic [2:0]  digit_count_ff, digit_count_in;
   logic [2:0]  padding_count_ff, padding_count_in;
   logic [15:0] fade_ms_ff, fade_ms_in;

   // captured item
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] number_ff, number_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;

   // display state
   logic [31:0] now_ms_ff, now_ms_in;
   logic [31:0] frame_ms_ff, frame_ms_in;
   logic [31:0] fade_start_ff, fade_start_in;
   logic [15:0] shown_ff, shown_in;
   logic [31:0] new_mask_ff, new_mask_in;
   logic [31:0] old_mask_ff, old_mask_in;
   logic [23:0] new_color_ff, new_color_in;
   logic [23:0] old_color_ff, old_color_in;

   // digit walk
   logic [14:0] t_ff, t_in;
   logic [14:0] quo_ff, quo_in;
   logic [2:0]  k_ff, k_in;
   logic [4:0]  pos_ff, pos_in;

   // frame
   logic [8:0]  p_ff, p_in;
   logic [15:0] blend_r_ff, blend_r_in;
   logic [15:0] blend_g_ff, blend_g_in;
   logic [15:0] blend_b_ff, blend_b_in;
   logic [4:0]  pix_ff, pix_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_index_ff, rsp_index_in;
   logic [7:0]  rsp_red_ff, rsp_red_in;
   logic [7:0]  rsp_green_ff, rsp_green_in;
   logic [7:0]  rsp_blue_ff, rsp_blue_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [2:0]  eff_dc;
   logic [2:0]  dcm1;
   logic [5:0]  dig_off;
   logic [4:0]  pos_init;
   logic [31:0] pad_mask;
   logic [5:0]  pix_sum;
   logic [5:0]  pix_total;
   logic [4:0]  last_idx;
   logic [31:0] elapsed;
   logic [31:0] since_frame;
   logic [sspc_pkg::DIV_WIDTH-1:0] div_quo;
   logic        div_busy;
   logic        div_done;
   logic        out_free;
   logic        num_same;
   logic        num_pos;

   logic [30:0] recip_prod;
   logic [14:0] quo_x10;
   logic [3:0]  digit_rem;
   logic [41:0] seg_shift;

   logic [6:0]  aq_num;
   logic [7:0]  aq_red;
   logic [7:0]  aq_green;
   logic [7:0]  aq_blue;
   logic [23:0] color_req;

   logic [8:0]  p_cur;
   logic [8:0]  inv_p;
   logic        in_old;
   logic        in_new;
   logic [8:0]  dim;
   logic [24:0] prod_r;
   logic [24:0] prod_g;
   logic [24:0] prod_b;

   assign eff_dc   = (digit_count_ff > EFF_MAX) ? EFF_MAX : digit_count_ff;
   assign dcm1     = eff_dc - 3'd1;
   assign dig_off  = 6'(dcm1) * 6'(sspc_pkg::DIGIT_PIXELS);
   // units digit sits in the last digit slot; unused when there are no digits
   assign pos_init = {2'b00, padding_count_ff} + dig_off[4:0];

   always_comb begin
      for (int i = 0; i < sspc_pkg::PIXEL_MAX; i++) begin
         pad_mask[i] = (i < int'(padding_count_ff));
      end
   end

   assign pix_sum   = 6'(eff_dc) * 6'(sspc_pkg::DIGIT_PIXELS) + {3'b000, padding_count_ff};
   assign pix_total = (pix_sum > 6'(sspc_pkg::PIXEL_MAX)) ? 6'(sspc_pkg::PIXEL_MAX) : pix_sum;
   assign last_idx  = 5'(pix_total - 6'd1);

   assign elapsed     = now_ms_ff - fade_start_ff;
   assign since_frame = now_ms_ff - frame_ms_ff;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign num_same = (number_ff == shown_ff);
   assign num_pos  = ~number_ff[15] & (number_ff != 16'd0);

   sspc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.frame_start),
      .dividend ({elapsed[15:0], 8'h00}),
      .divisor  (fade_ms_ff),
      .quotient (div_quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   // digit extraction
   assign recip_prod = {16'h0000, t_ff} * 31'(sspc_pkg::DIV10_RECIP);
   assign quo_x10    = (quo_ff << 3) + (quo_ff << 1);
   assign digit_rem  = 4'(t_ff - quo_x10);
   assign seg_shift  = {35'h0, sspc_pkg::seg_of(digit_rem)} << pos_ff;

   // air quality map
   always_comb begin
      if (number_ff[15]) begin
         aq_num = 7'd0;
      end else if (number_ff > 16'(sspc_pkg::AQ_MAX)) begin
         aq_num = 7'(sspc_pkg::AQ_MAX);
      end else begin
         aq_num = number_ff[6:0];
      end
      aq_red   = (aq_num > 7'(sspc_pkg::AQ_RED_KNEE)) ?
                 8'((aq_num - 7'(sspc_pkg::AQ_RED_KNEE)) >> 1) : 8'd0;
      aq_green = (aq_num < 7'(sspc_pkg::AQ_GREEN_KNEE)) ?
                 8'(7'(sspc_pkg::AQ_GREEN_KNEE) - aq_num) : 8'd0;
      aq_blue  = (aq_num <= 7'(sspc_pkg::AQ_BLUE_KNEE)) ?
                 8'(7'(sspc_pkg::AQ_BLUE_KNEE) - aq_num) : 8'd0;
   end

   assign color_req = {red_ff, green_ff, blue_ff};

   // progress saturates at 1.0; also covers a zero fade time
   assign p_cur = (div_quo > sspc_pkg::DIV_WIDTH'(sspc_pkg::PROG_ONE)) ?
                  9'(sspc_pkg::PROG_ONE) : div_quo[8:0];
   assign inv_p = 9'(sspc_pkg::PROG_ONE) - p_ff;

   assign in_old = old_mask_ff[pix_ff];
   assign in_new = new_mask_ff[pix_ff];

   always_comb begin
      if (in_old && in_new) begin
         dim = 9'(sspc_pkg::PROG_ONE);
      end else if (in_new) begin
         dim = p_ff;
      end else if (in_old) begin
         dim = inv_p;
      end else begin
         dim = 9'd0;
      end
   end

   assign prod_r = {9'h000, blend_r_ff} * {16'h0000, dim};
   assign prod_g = {9'h000, blend_g_ff} * {16'h0000, dim};
   assign prod_b = {9'h000, blend_b_ff} * {16'h0000, dim};

   always_comb begin
      digit_count_in   = digit_count_ff;
      padding_count_in = padding_count_ff;
      fade_ms_in       = fade_ms_ff;
      cmd_in           = cmd_ff;
      number_in        = number_ff;
      red_in           = red_ff;
      green_in         = green_ff;
      blue_in          = blue_ff;
      now_ms_in        = now_ms_ff;
      frame_ms_in      = frame_ms_ff;
      fade_start_in    = fade_start_ff;
      shown_in         = shown_ff;
      new_mask_in      = new_mask_ff;
      old_mask_in      = old_mask_ff;
      new_color_in     = new_color_ff;
      old_color_in     = old_color_ff;
      t_in             = t_ff;
      quo_in           = quo_ff;
      k_in             = k_ff;
      pos_in           = pos_ff;
      p_in             = p_ff;
      blend_r_in       = blend_r_ff;
      blend_g_in       = blend_g_ff;
      blend_b_in       = blend_b_ff;
      pix_in           = pix_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_index_in     = rsp_index_ff;
      rsp_red_in       = rsp_red_ff;
      rsp_green_in     = rsp_green_ff;
      rsp_blue_in      = rsp_blue_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            sspc_pkg::CSR_DIGIT_COUNT:   digit_count_in   = csr_wdata[2:0];
            sspc_pkg::CSR_PADDING_COUNT: padding_count_in = csr_wdata[2:0];
            sspc_pkg::CSR_FADE_MS:       fade_ms_in       = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         cmd_in    = req_cmd;
         number_in = req_number;
         red_in    = req_red_in;
         green_in  = req_green_in;
         blue_in   = req_blue_in;
      end

      if (cmd.now_inc) begin
         now_ms_in = now_ms_ff + 32'd1;
      end

      if (cmd.aq_map) begin
         number_in = {9'h000, aq_num};
         red_in    = aq_red;
         green_in  = aq_green;
         blue_in   = aq_blue;
      end

      if (cmd.color_put && (color_req != new_color_ff)) begin
         old_color_in  = new_color_ff;
         new_color_in  = color_req;
         fade_start_in = now_ms_ff;
      end

      if (cmd.num_put && !num_same) begin
         shown_in    = number_ff;
         old_mask_in = new_mask_ff;
         new_mask_in = '0;
         if (num_pos) begin
            new_mask_in   = pad_mask;
            t_in          = number_ff[14:0];
            k_in          = 3'd0;
            pos_in        = pos_init;
            fade_start_in = now_ms_ff;
         end
      end

      if (cmd.digit_div) begin
         quo_in = 15'(recip_prod >> sspc_pkg::DIV10_SHIFT);
      end

      if (cmd.digit_put) begin
         new_mask_in = new_mask_ff | seg_shift[31:0];
         t_in        = quo_ff;
         k_in        = k_ff + 3'd1;
         pos_in      = pos_ff - 5'(sspc_pkg::DIGIT_PIXELS);
      end

      if (cmd.frame_start) begin
         frame_ms_in = now_ms_ff;
      end

      if (cmd.blend) begin
         p_in       = p_cur;
         pix_in     = 5'd0;
         blend_r_in = 16'(({9'h000, old_color_ff[23:16]} * {8'h00, 9'(9'(sspc_pkg::PROG_ONE) - p_cur)})
                      + ({9'h000, new_color_ff[23:16]} * {8'h00, p_cur}));
         blend_g_in = 16'(({9'h000, old_color_ff[15:8]} * {8'h00, 9'(9'(sspc_pkg::PROG_ONE) - p_cur)})
                      + ({9'h000, new_color_ff[15:8]} * {8'h00, p_cur}));
         blend_b_in = 16'(({9'h000, old_color_ff[7:0]} * {8'h00, 9'(9'(sspc_pkg::PROG_ONE) - p_cur)})
                      + ({9'h000, new_color_ff[7:0]} * {8'h00, p_cur}));
      end

      if (cmd.pix_emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = pix_ff;
         rsp_red_in   = prod_r[23:16];
         rsp_green_in = prod_g[23:16];
         rsp_blue_in  = prod_b[23:16];
         rsp_last_in  = (pix_ff == last_idx);
         pix_in       = pix_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff   <= sspc_pkg::DIGIT_COUNT_RST;
         padding_count_ff <= sspc_pkg::PADDING_COUNT_RST;
         fade_ms_ff       <= sspc_pkg::FADE_MS_RST;
         now_ms_ff        <= '0;
         frame_ms_ff      <= '0;
         fade_start_ff    <= '0;
         shown_ff         <= '0;
         new_mask_ff      <= '0;
         old_mask_ff      <= '0;
         new_color_ff     <= '0;
         old_color_ff     <= '0;
         pix_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         digit_count_ff   <= digit_count_in;
         padding_count_ff <= padding_count_in;
         fade_ms_ff       <= fade_ms_in;
         now_ms_ff        <= now_ms_in;
         frame_ms_ff      <= frame_ms_in;
         fade_start_ff    <= fade_start_in;
         shown_ff         <= shown_in;
         new_mask_ff      <= new_mask_in;
         old_mask_ff      <= old_mask_in;
         new_color_ff     <= new_color_in;
         old_color_ff     <= old_color_in;
         pix_ff           <= pix_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      number_ff    <= number_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      t_ff         <= t_in;
      quo_ff       <= quo_in;
      k_ff         <= k_in;
      pos_ff       <= pos_in;
      p_ff         <= p_in;
      blend_r_ff   <= blend_r_in;
      blend_g_ff   <= blend_g_in;
      blend_b_ff   <= blend_b_in;
      rsp_index_ff <= rsp_index_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      status            = '0;
      status.cmd        = cmd_ff;
      status.num_same   = num_same;
      status.num_pos    = num_pos;
      status.digit_done = (t_ff == 15'd0) || (k_ff == eff_dc);
      status.frame_due  = (since_frame > GAP) && (elapsed <= {16'h0000, fade_ms_ff});
      status.div_busy   = div_busy;
      status.div_done   = div_done;
      status.pix_none   = (pix_total == 6'd0);
      status.pix_last   = (pix_ff == last_idx);
      status.out_free   = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_red_out     = rsp_red_ff;
   assign rsp_green_out   = rsp_green_ff;
   assign rsp_blue_out    = rsp_blue_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/sspc_ctrl.sv
`default_nettype none

module sspc_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire sspc_pkg::sspc_status_type status,
   output sspc_pkg::sspc_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_COLOR,
      S_NUMBER,
      S_DIGIT_DIV,
      S_DIGIT_PUT,
      S_CHECK,
      S_DIV,
      S_BLEND,
      S_PIXEL
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.cmd)
               sspc_pkg::CMD_TICK: begin
                  cmd.now_inc = 1'b1;
                  state_in    = S_CHECK;
               end
               sspc_pkg::CMD_NUMBER: state_in = S_NUMBER;
               sspc_pkg::CMD_COLOR:  state_in = S_COLOR;
               sspc_pkg::CMD_AQ: begin
                  cmd.aq_map = 1'b1;
                  state_in   = S_COLOR;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_COLOR: begin
            cmd.color_put = 1'b1;
            // air quality sets the number right after the color
            state_in = (status.cmd == sspc_pkg::CMD_AQ) ? S_NUMBER : S_IDLE;
         end
         S_NUMBER: begin
            cmd.num_put = 1'b1;
            state_in    = (!status.num_same && status.num_pos) ? S_DIGIT_DIV : S_IDLE;
         end
         S_DIGIT_DIV: begin
            if (status.digit_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.digit_div = 1'b1;
               state_in      = S_DIGIT_PUT;
            end
         end
         S_DIGIT_PUT: begin
            cmd.digit_put = 1'b1;
            state_in      = S_DIGIT_DIV;
         end
         S_CHECK: begin
            if (status.frame_due) begin
               cmd.frame_start = 1'b1;
               state_in        = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = status.pix_none ? S_IDLE : S_PIXEL;
         end
         S_PIXEL: begin
            if (status.out_free) begin
               cmd.pix_emit = 1'b1;
               if (status.pix_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule

`default_nettype wire

### hw/rtl/seven_segment_pixel_crossfade_unit.sv
// A tick with no frame due, a color item, or a zero, negative or unchanged number ends at its
// update; a new positive number then places each digit, and an air-quality item maps its color
// first. A frame tick runs the bit-serial progress divider, blends, then emits the pixels in
// order (up to 32), pausing on rsp_stall. One item at a time; output is registered, so the next
// item is taken while the last pixel waits. Reset: digit_count 4, padding 0, fade_ms 1000;
// times, shown number, masks, colors and pixel index 0; rsp_valid low; the rest is not reset.
`default_nettype none

module seven_segment_pixel_crossfade_unit #(
   parameter int MAX_DIGITS   = sspc_pkg::MAX_DIGITS_DEF,
   parameter int FRAME_GAP_MS = sspc_pkg::FRAME_GAP_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_cmd,
   input  wire logic signed [15:0] req_number,
   input  wire logic [7:0]         req_red_in,
   input  wire logic [7:0]         req_green_in,
   input  wire logic [7:0]         req_blue_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [4:0]              rsp_pixel_index,
   output logic [7:0]              rsp_red_out,
   output logic [7:0]              rsp_green_out,
   output logic [7:0]              rsp_blue_out,
   output logic                    rsp_last
);

   sspc_pkg::sspc_cmd_type    cmd;
   sspc_pkg::sspc_status_type status;

   sspc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sspc_dp #(
      .MAX_DIGITS   (MAX_DIGITS),
      .FRAME_GAP_MS (FRAME_GAP_MS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_number      (req_number),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .status          (status)
   );

   // one item at a time: an accepted item closes the input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after an accepted item");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_emit |-> status.out_free)
      else $error("pixel written over a pending item");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_start |-> !status.div_busy)
      else $error("progress divider restarted while busy");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.pix_emit))
      else $error("result valid without a pixel emit");

endmodule

`default_nettype wire
